FILE: rtl/uss_pkg.sv
// ----------------------------------------------------------------------------
// Update session supervisor package
// Shared widths, register indexes, feature bits, exit reason codes and reset
// values for the supervisor core, its channels and its checker.
// ----------------------------------------------------------------------------
package uss_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned STATE_W    = 8;
	localparam int unsigned REASON_W   = 3;
	localparam int unsigned FEAT_W     = 4;
	localparam int unsigned CNT16_W    = 16;
	localparam int unsigned CNT24_W    = 24;
	localparam int unsigned IDLE_MS_W  = 10;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_ENABLES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_HALF_MS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPLETE_DELAY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_HOLD       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INACTIVITY_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_IDLE_LEVEL = 3'd6;

	// Feature enable bit positions
	localparam int unsigned FEAT_HEARTBEAT  = 0;
	localparam int unsigned FEAT_CONNECT    = 1;
	localparam int unsigned FEAT_BUTTON     = 2;
	localparam int unsigned FEAT_INACTIVITY = 3;

	// Exit reasons
	localparam logic [REASON_W-1:0] REASON_NONE       = 3'd0;
	localparam logic [REASON_W-1:0] REASON_CONNECT    = 3'd1;
	localparam logic [REASON_W-1:0] REASON_COMPLETED  = 3'd2;
	localparam logic [REASON_W-1:0] REASON_BUTTON     = 3'd3;
	localparam logic [REASON_W-1:0] REASON_INACTIVITY = 3'd4;

	localparam logic [IDLE_MS_W-1:0] MS_PER_SECOND = 10'd1000;

	// Register reset values
	localparam logic [FEAT_W-1:0]  RST_FEATURE_ENABLES = 4'hF;
	localparam logic [CNT16_W-1:0] RST_HEARTBEAT_HALF  = 16'd250;
	localparam logic [CNT24_W-1:0] RST_CONNECT_TIMEOUT = 24'd10000;
	localparam logic [CNT16_W-1:0] RST_COMPLETE_DELAY  = 16'd1000;
	localparam logic [CNT16_W-1:0] RST_BUTTON_HOLD     = 16'd2000;
	localparam logic [CNT16_W-1:0] RST_INACTIVITY_LIM  = 16'd60;
	localparam logic               RST_BUTTON_IDLE     = 1'b0;

endpackage

FILE: rtl/uss_req_if.sv
// ----------------------------------------------------------------------------
// Supervisor tick request channel
// One request per millisecond tick: button level and session status.
// ----------------------------------------------------------------------------
interface uss_req_if;
	logic                         valid;
	logic                         ready;
	logic                         button_level;
	logic [uss_pkg::STATE_W-1:0]  session_state;
	logic                         session_in_init;
	logic                         session_done;

	modport source (output valid, button_level, session_state, session_in_init,
		session_done, input ready);
	modport sink (input valid, button_level, session_state, session_in_init,
		session_done, output ready);
endinterface

FILE: rtl/uss_rsp_if.sv
// ----------------------------------------------------------------------------
// Supervisor result channel
// One result per tick request: LED level, finished flag and exit reason.
// ----------------------------------------------------------------------------
interface uss_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         led_level;
	logic                         finished;
	logic [uss_pkg::REASON_W-1:0] exit_reason;

	modport source (output valid, led_level, finished, exit_reason, input ready);
	modport sink (input valid, led_level, finished, exit_reason, output ready);
endinterface

FILE: rtl/update_session_supervisor_core.sv
// ----------------------------------------------------------------------------
// Update session supervisor core
// Heartbeat LED and session exit supervision, one millisecond tick per request.
// ----------------------------------------------------------------------------
// Path: the request is taken into the input register, then the tick logic
//   feeds the result register once that register is empty or being taken.
// Throughput: one request per cycle while results are taken: the result
//   register frees in the cycle its result is taken; stage 1 runs back to back.
// Reset (arst_n low, asynchronous): registers return to their reset values,
//   all counters clear, no exit reason, both channels empty.
// ----------------------------------------------------------------------------
module update_session_supervisor_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [uss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [uss_pkg::CFG_DATA_W-1:0]  cfg_data,
	uss_req_if.sink                         req,
	uss_rsp_if.source                       rsp
);

	// Saturating increments
	function automatic logic [uss_pkg::CNT16_W-1:0] sat16(
		input logic [uss_pkg::CNT16_W-1:0] v);
		sat16 = (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [uss_pkg::CNT24_W-1:0] sat24(
		input logic [uss_pkg::CNT24_W-1:0] v);
		sat24 = (v == '1) ? v : v + 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [uss_pkg::FEAT_W-1:0]  feat_q;
	logic [uss_pkg::CNT16_W-1:0] hb_half_q;
	logic [uss_pkg::CNT24_W-1:0] connect_to_q;
	logic [uss_pkg::CNT16_W-1:0] done_delay_q;
	logic [uss_pkg::CNT16_W-1:0] hold_q;
	logic [uss_pkg::CNT16_W-1:0] idle_limit_q;
	logic                        idle_level_q;

	// Write only while idle, unenforced by the block; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feat_q       <= uss_pkg::RST_FEATURE_ENABLES;
			hb_half_q    <= uss_pkg::RST_HEARTBEAT_HALF;
			connect_to_q <= uss_pkg::RST_CONNECT_TIMEOUT;
			done_delay_q <= uss_pkg::RST_COMPLETE_DELAY;
			hold_q       <= uss_pkg::RST_BUTTON_HOLD;
			idle_limit_q <= uss_pkg::RST_INACTIVITY_LIM;
			idle_level_q <= uss_pkg::RST_BUTTON_IDLE;
		end else if (cfg_we) begin
			case (cfg_index)
				uss_pkg::CFG_FEATURE_ENABLES: begin
					feat_q <= cfg_data[uss_pkg::FEAT_W-1:0];
				end
				uss_pkg::CFG_HEARTBEAT_HALF_MS: begin
					hb_half_q <= cfg_data[uss_pkg::CNT16_W-1:0];
				end
				uss_pkg::CFG_CONNECT_TIMEOUT: begin
					connect_to_q <= cfg_data[uss_pkg::CNT24_W-1:0];
				end
				uss_pkg::CFG_COMPLETE_DELAY: begin
					done_delay_q <= cfg_data[uss_pkg::CNT16_W-1:0];
				end
				uss_pkg::CFG_BUTTON_HOLD: begin
					hold_q <= cfg_data[uss_pkg::CNT16_W-1:0];
				end
				uss_pkg::CFG_INACTIVITY_LIMIT: begin
					idle_limit_q <= cfg_data[uss_pkg::CNT16_W-1:0];
				end
				uss_pkg::CFG_BUTTON_IDLE_LEVEL: begin
					idle_level_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input register: take a request whenever stage 1 is empty or moves on
	// ------------------------------------------------------------------
	logic                        valid_s1;
	logic                        level_s1;
	logic [uss_pkg::STATE_W-1:0] code_s1;
	logic                        init_s1;
	logic                        done_s1;
	logic                        rsp_valid_q;
	logic                        advance;

	// Stage 1 moves into the result register when that register is empty or
	// its result is being taken in this cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			level_s1 <= req.button_level;
			code_s1  <= req.session_state;
			init_s1  <= req.session_in_init;
			done_s1  <= req.session_done;
		end
	end

	// ------------------------------------------------------------------
	// Supervisor state
	// ------------------------------------------------------------------
	logic                          led_on_q,     led_on_d;
	logic [uss_pkg::CNT16_W-1:0]   led_el_q,     led_el_d;
	logic [uss_pkg::CNT24_W-1:0]   since_q,      since_d;
	logic                          done_seen_q,  done_seen_d;
	logic [uss_pkg::CNT16_W-1:0]   done_el_q,    done_el_d;
	logic                          tracked_q,    tracked_d;
	logic [uss_pkg::CNT16_W-1:0]   btn_el_q,     btn_el_d;
	logic [uss_pkg::STATE_W-1:0]   last_code_q,  last_code_d;
	logic                          primed_q,     primed_d;
	logic [uss_pkg::IDLE_MS_W-1:0] idle_ms_q,    idle_ms_d;
	logic [uss_pkg::CNT16_W-1:0]   idle_s_q,     idle_s_d;
	logic [uss_pkg::REASON_W-1:0]  exit_q;

	logic [uss_pkg::CNT16_W-1:0]   led_inc;
	logic [uss_pkg::IDLE_MS_W-1:0] ms_inc;
	logic [uss_pkg::STATE_W-1:0]   ref_code;
	logic                          hit_connect, hit_done, hit_button, hit_idle;
	logic [uss_pkg::REASON_W-1:0]  reason_d;
	logic [uss_pkg::REASON_W-1:0]  reason_out;

	// One tick of all supervisors. Updates made after an exit fires are never
	// observed, since the whole state freezes once the exit reason is set.
	always_comb begin
		led_on_d    = led_on_q;
		led_el_d    = led_el_q;
		done_seen_d = done_seen_q;
		done_el_d   = done_el_q;
		tracked_d   = tracked_q;
		btn_el_d    = btn_el_q;
		last_code_d = last_code_q;
		primed_d    = primed_q;
		idle_ms_d   = idle_ms_q;
		idle_s_d    = idle_s_q;
		hit_done    = 1'b0;
		hit_button  = 1'b0;
		hit_idle    = 1'b0;
		ms_inc      = idle_ms_q + 1'b1;
		ref_code    = primed_q ? last_code_q : code_s1;

		// Heartbeat: toggle and fold the elapsed count back by one half period
		led_inc = sat16(led_el_q);
		if (feat_q[uss_pkg::FEAT_HEARTBEAT]) begin
			led_el_d = led_inc;
			if (led_inc >= hb_half_q) begin
				led_on_d = ~led_on_q;
				led_el_d = led_inc - hb_half_q;
			end
		end

		// Connect timeout: since_start counts whatever the enables say
		since_d     = sat24(since_q);
		hit_connect = feat_q[uss_pkg::FEAT_CONNECT] && init_s1
			&& (since_d >= connect_to_q);

		// Completion: arm on the first done tick, count from the next one
		if (!done_seen_q) begin
			if (done_s1) begin
				done_seen_d = 1'b1;
				done_el_d   = '0;
			end
		end else begin
			done_el_d = sat16(done_el_q);
			hit_done  = (done_el_d >= done_delay_q);
		end

		// Exit button: restart on any edge, count while held away from idle
		if (feat_q[uss_pkg::FEAT_BUTTON]) begin
			if (level_s1 != tracked_q) begin
				tracked_d = level_s1;
				btn_el_d  = '0;
			end else if (tracked_q != idle_level_q) begin
				btn_el_d   = sat16(btn_el_q);
				hit_button = (btn_el_d >= hold_q);
			end
		end

		// Inactivity: the first tick captures the code and counts as idle
		if (feat_q[uss_pkg::FEAT_INACTIVITY]) begin
			primed_d    = 1'b1;
			last_code_d = code_s1;
			if (code_s1 != ref_code) begin
				idle_ms_d = '0;
				idle_s_d  = '0;
			end else if (ms_inc >= uss_pkg::MS_PER_SECOND) begin
				idle_ms_d = ms_inc - uss_pkg::MS_PER_SECOND;
				idle_s_d  = sat16(idle_s_q);
				hit_idle  = (idle_s_d >= idle_limit_q);
			end else begin
				idle_ms_d = ms_inc;
			end
		end

		// Earlier conditions take priority
		if (hit_connect) begin
			reason_d = uss_pkg::REASON_CONNECT;
		end else if (hit_done) begin
			reason_d = uss_pkg::REASON_COMPLETED;
		end else if (hit_button) begin
			reason_d = uss_pkg::REASON_BUTTON;
		end else if (hit_idle) begin
			reason_d = uss_pkg::REASON_INACTIVITY;
		end else begin
			reason_d = uss_pkg::REASON_NONE;
		end

		reason_out = (exit_q != uss_pkg::REASON_NONE) ? exit_q : reason_d;
	end

	// Advance the state on each tick until the session has ended, then hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_on_q    <= 1'b0;
			led_el_q    <= '0;
			since_q     <= '0;
			done_seen_q <= 1'b0;
			done_el_q   <= '0;
			tracked_q   <= uss_pkg::RST_BUTTON_IDLE;
			btn_el_q    <= '0;
			primed_q    <= 1'b0;
			idle_ms_q   <= '0;
			idle_s_q    <= '0;
			exit_q      <= uss_pkg::REASON_NONE;
		end else if (advance && (exit_q == uss_pkg::REASON_NONE)) begin
			led_on_q    <= led_on_d;
			led_el_q    <= led_el_d;
			since_q     <= since_d;
			done_seen_q <= done_seen_d;
			done_el_q   <= done_el_d;
			tracked_q   <= tracked_d;
			btn_el_q    <= btn_el_d;
			primed_q    <= primed_d;
			idle_ms_q   <= idle_ms_d;
			idle_s_q    <= idle_s_d;
			exit_q      <= reason_d;
		end
	end

	// The captured code only matters once primed, so it needs no reset
	always_ff @(posedge clk) begin
		if (advance && (exit_q == uss_pkg::REASON_NONE)) begin
			last_code_q <= last_code_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic                         led_q;
	logic                         fin_q;
	logic [uss_pkg::REASON_W-1:0] reason_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// After exit the LED is driven low and the reason holds
	always_ff @(posedge clk) begin
		if (advance) begin
			reason_q <= reason_out;
			fin_q    <= (reason_out != uss_pkg::REASON_NONE);
			led_q    <= (reason_out == uss_pkg::REASON_NONE)
				&& feat_q[uss_pkg::FEAT_HEARTBEAT] && led_on_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.led_level   = led_q;
	assign rsp.finished    = fin_q;
	assign rsp.exit_reason = reason_q;

endmodule

FILE: rtl/uss_checker.sv
// ----------------------------------------------------------------------------
// Update session supervisor checker
// Port-level result channel checks: sticky exit, output coding, stall hold.
// ----------------------------------------------------------------------------
module uss_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         led_level,
	input logic                         finished,
	input logic [uss_pkg::REASON_W-1:0] exit_reason
);

	logic                         seen_fin_q;
	logic [uss_pkg::REASON_W-1:0] seen_reason_q;

	// Remember the first exit reason delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_fin_q    <= 1'b0;
			seen_reason_q <= uss_pkg::REASON_NONE;
		end else if (rsp_valid && rsp_ready && finished && !seen_fin_q) begin
			seen_fin_q    <= 1'b1;
			seen_reason_q <= exit_reason;
		end
	end

	a_exit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && seen_fin_q) |-> (finished && (exit_reason == seen_reason_q)))
		else $error("exit reason changed after the session ended");

	a_finished_coding: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (finished == (exit_reason != uss_pkg::REASON_NONE)))
		else $error("finished flag disagrees with exit reason");

	a_led_dark_after_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && finished) |-> !led_level)
		else $error("LED driven after the session ended");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(finished)
			&& $stable(exit_reason) && $stable(led_level)))
		else $error("stalled result changed");

endmodule

bind update_session_supervisor_core uss_checker u_uss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.led_level   (rsp.led_level),
	.finished    (rsp.finished),
	.exit_reason (rsp.exit_reason)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Update session supervisor core testbench
// Drives millisecond tick requests into the supervisor and predicts every
// result with a cycle-free model of the heartbeat and the exit conditions.
// The checker process takes results under random back-pressure and compares
// each one, field by field, with the oldest prediction. Since only one reset
// is allowed and an exit is sticky, the sender steers random traffic away
// from every exit and ends the run with one deliberately provoked exit.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles to let pass once the last result is in
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned RANDOM_QUOTA = 283;

	typedef struct packed {
		logic [uss_pkg::FEAT_W-1:0]  feat;
		logic [uss_pkg::CNT16_W-1:0] hb_half;
		logic [uss_pkg::CNT24_W-1:0] conn_limit;
		logic [uss_pkg::CNT16_W-1:0] done_delay;
		logic [uss_pkg::CNT16_W-1:0] hold_limit;
		logic [uss_pkg::CNT16_W-1:0] idle_limit;
		logic                        idle_level;
	} sup_regs_t;

	typedef struct packed {
		logic                          led_on;
		logic [uss_pkg::CNT16_W-1:0]   led_elapsed;
		logic [uss_pkg::CNT24_W-1:0]   since_start;
		logic                          done_seen;
		logic [uss_pkg::CNT16_W-1:0]   done_elapsed;
		logic                          btn_tracked;
		logic [uss_pkg::CNT16_W-1:0]   btn_elapsed;
		logic [uss_pkg::STATE_W-1:0]   last_code;
		logic                          primed;
		logic [uss_pkg::IDLE_MS_W-1:0] idle_ms;
		logic [uss_pkg::CNT16_W-1:0]   idle_sec;
		logic [uss_pkg::REASON_W-1:0]  reason;
	} sup_state_t;

	typedef struct packed {
		logic                        level;
		logic [uss_pkg::STATE_W-1:0] code;
		logic                        in_init;
		logic                        done;
	} tick_t;

	typedef struct packed {
		logic                         led;
		logic                         finished;
		logic [uss_pkg::REASON_W-1:0] reason;
	} outcome_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [uss_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [uss_pkg::CFG_DATA_W-1:0] cfg_data;

	uss_req_if req_ch ();
	uss_rsp_if rsp_ch ();

	// Predictor copy of the registers and the supervision state
	sup_regs_t   sup_regs;
	sup_state_t  sup_st;
	outcome_t    pending_results [$];
	int unsigned fail_count   = 0;
	int unsigned send_gap_pct = 9;
	int unsigned recv_gap_pct = 76;

	update_session_supervisor_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("[update_session_supervisor_core] ERROR");
		$finish;
	end

	function automatic logic [uss_pkg::CNT16_W-1:0] bump16(
		input logic [uss_pkg::CNT16_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [uss_pkg::CNT24_W-1:0] bump24(
		input logic [uss_pkg::CNT24_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Advance the supervision state by one millisecond tick. Conditions are
	// checked in priority order; the first one to fire ends the session and
	// everything after it in the tick is skipped.
	function automatic sup_state_t supervise_tick(input sup_regs_t r, input sup_state_t s,
		input tick_t t);
		sup_state_t n;
		n = s;
		// once ended, nothing moves again
		if (n.reason != uss_pkg::REASON_NONE)
			return n;
		if (r.feat[uss_pkg::FEAT_HEARTBEAT]) begin
			n.led_elapsed = bump16(n.led_elapsed);
			// a zero period toggles on every tick
			if (n.led_elapsed >= r.hb_half) begin
				n.led_on      = ~n.led_on;
				n.led_elapsed = n.led_elapsed - r.hb_half;
			end
		end
		// runs whatever the enables say
		n.since_start = bump24(n.since_start);
		if (r.feat[uss_pkg::FEAT_CONNECT] && t.in_init && n.since_start >= r.conn_limit) begin
			n.reason = uss_pkg::REASON_CONNECT;
			return n;
		end
		// completion has no enable bit
		if (!n.done_seen) begin
			if (t.done) begin
				n.done_seen    = 1'b1;
				n.done_elapsed = '0;
			end
		end else begin
			n.done_elapsed = bump16(n.done_elapsed);
			if (n.done_elapsed >= r.done_delay) begin
				n.reason = uss_pkg::REASON_COMPLETED;
				return n;
			end
		end
		if (r.feat[uss_pkg::FEAT_BUTTON]) begin
			// pressed means the tracked level differs from the current idle level
			if (t.level != n.btn_tracked) begin
				n.btn_tracked = t.level;
				n.btn_elapsed = '0;
			end else if (n.btn_tracked != r.idle_level) begin
				n.btn_elapsed = bump16(n.btn_elapsed);
				if (n.btn_elapsed >= r.hold_limit) begin
					n.reason = uss_pkg::REASON_BUTTON;
					return n;
				end
			end
		end
		if (r.feat[uss_pkg::FEAT_INACTIVITY]) begin
			// the first tick captures the code and already counts as idle
			if (!n.primed) begin
				n.primed    = 1'b1;
				n.last_code = t.code;
			end
			if (t.code != n.last_code) begin
				n.last_code = t.code;
				n.idle_ms   = '0;
				n.idle_sec  = '0;
			end else begin
				n.idle_ms = n.idle_ms + 1'b1;
				if (n.idle_ms >= uss_pkg::MS_PER_SECOND) begin
					n.idle_ms  = n.idle_ms - uss_pkg::MS_PER_SECOND;
					n.idle_sec = bump16(n.idle_sec);
					if (n.idle_sec >= r.idle_limit) begin
						n.reason = uss_pkg::REASON_INACTIVITY;
						return n;
					end
				end
			end
		end
		return n;
	endfunction

	function automatic outcome_t outcome_of(input sup_regs_t r, input sup_state_t s);
		outcome_t o;
		if (s.reason != uss_pkg::REASON_NONE) begin
			o.led      = 1'b0;
			o.finished = 1'b1;
			o.reason   = s.reason;
		end else begin
			o.led      = r.feat[uss_pkg::FEAT_HEARTBEAT] & s.led_on;
			o.finished = 1'b0;
			o.reason   = uss_pkg::REASON_NONE;
		end
		return o;
	endfunction

	// Bend a tick just enough to keep the session alive: leave init, toggle
	// the button, change the state code. Completion is kept away by holding
	// done low unless the delay sits at its maximum.
	function automatic tick_t keep_alive(input tick_t t);
		tick_t                       k;
		sup_state_t                  trial;
		logic [uss_pkg::STATE_W-1:0] flip;
		k = t;
		if (!sup_st.done_seen && sup_regs.done_delay != '1)
			k.done = 1'b0;
		trial = supervise_tick(sup_regs, sup_st, k);
		if (trial.reason != uss_pkg::REASON_NONE) begin
			flip      = 8'($urandom_range(1, 255));
			k.in_init = 1'b0;
			k.level   = ~sup_st.btn_tracked;
			k.code    = sup_st.last_code ^ flip;
		end
		return k;
	endfunction

	// Send one tick request; predict its result before it goes out
	task automatic send_request(input tick_t t, input bit guarded);
		tick_t k;
		k = guarded ? keep_alive(t) : t;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sup_st = supervise_tick(sup_regs, sup_st, k);
		pending_results.push_back(outcome_of(sup_regs, sup_st));
		req_ch.valid           <= 1'b1;
		req_ch.button_level    <= k.level;
		req_ch.session_state   <= k.code;
		req_ch.session_in_init <= k.in_init;
		req_ch.session_done    <= k.done;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
	endtask

	// Hold off the sender until every result is in and the pipe is empty
	task automatic drain_block();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [uss_pkg::CFG_IDX_W-1:0] idx,
		input logic [uss_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			uss_pkg::CFG_FEATURE_ENABLES:
				sup_regs.feat       = data[uss_pkg::FEAT_W-1:0];
			uss_pkg::CFG_HEARTBEAT_HALF_MS:
				sup_regs.hb_half    = data[uss_pkg::CNT16_W-1:0];
			uss_pkg::CFG_CONNECT_TIMEOUT:
				sup_regs.conn_limit = data[uss_pkg::CNT24_W-1:0];
			uss_pkg::CFG_COMPLETE_DELAY:
				sup_regs.done_delay = data[uss_pkg::CNT16_W-1:0];
			uss_pkg::CFG_BUTTON_HOLD:
				sup_regs.hold_limit = data[uss_pkg::CNT16_W-1:0];
			uss_pkg::CFG_INACTIVITY_LIMIT:
				sup_regs.idle_limit = data[uss_pkg::CNT16_W-1:0];
			uss_pkg::CFG_BUTTON_IDLE_LEVEL:
				sup_regs.idle_level = data[0];
			default: ;
		endcase
	endtask

	// Reset values, field extremes on every input
	task automatic test_power_on_defaults();
		send_request({1'b0, 8'h00, 1'b1, 1'b1}, 1'b1);
		send_request({1'b1, 8'hFF, 1'b0, 1'b0}, 1'b1);
		send_request({1'b1, 8'hFF, 1'b1, 1'b1}, 1'b1);
		send_request({1'b0, 8'h00, 1'b0, 1'b0}, 1'b1);
		send_request({1'b1, 8'h55, 1'b1, 1'b0}, 1'b1);
		drain_block();
	endtask

	// Zero period toggles every tick; one and the maximum bracket the rest
	task automatic test_heartbeat_periods();
		logic [uss_pkg::CNT16_W-1:0] periods [3];
		tick_t                       t;
		periods[0] = '0;
		periods[1] = 16'd1;
		periods[2] = '1;
		foreach (periods[p]) begin
			write_reg(uss_pkg::CFG_HEARTBEAT_HALF_MS, {8'd0, periods[p]});
			repeat (4) begin
				t.level   = 1'($urandom_range(0, 1));
				t.code    = 8'($urandom_range(0, 255));
				t.in_init = 1'($urandom_range(0, 1));
				t.done    = 1'b0;
				send_request(t, 1'b1);
			end
			drain_block();
		end
	endtask

	// Every feature off: LED held low, only the start counter moves
	task automatic test_feature_masks();
		write_reg(uss_pkg::CFG_HEARTBEAT_HALF_MS, 24'd1);
		write_reg(uss_pkg::CFG_FEATURE_ENABLES, '0);
		send_request({1'b1, 8'h3C, 1'b1, 1'b0}, 1'b1);
		send_request({1'b1, 8'h3C, 1'b1, 1'b0}, 1'b1);
		drain_block();
		write_reg(uss_pkg::CFG_FEATURE_ENABLES, {20'd0, uss_pkg::RST_FEATURE_ENABLES});
	endtask

	// Swap the idle level to high and drive the button away from it and back
	task automatic test_button_idle_swap();
		write_reg(uss_pkg::CFG_BUTTON_IDLE_LEVEL, 24'd1);
		send_request({1'b0, 8'h10, 1'b0, 1'b0}, 1'b1);
		send_request({1'b0, 8'h10, 1'b0, 1'b0}, 1'b1);
		send_request({1'b1, 8'h10, 1'b0, 1'b0}, 1'b1);
		drain_block();
		write_reg(uss_pkg::CFG_BUTTON_IDLE_LEVEL, 24'd0);
	endtask

	// Steady stretches of session activity with a little noise on top.
	// Phase 0 keeps the limits short, phase 1 puts the timeout, hold and idle limits at their maxima,
	// phase 2 lets completion be flagged with the delay parked at its maximum.
	task automatic test_random_sessions(input int unsigned phase);
		int unsigned sent;
		int unsigned len;
		bit          noisy;
		bit          rewritten;
		tick_t       t;
		tick_t       item;
		drain_block();
		case (phase)
			0: begin
				write_reg(uss_pkg::CFG_FEATURE_ENABLES, 24'($urandom_range(0, 15)));
				write_reg(uss_pkg::CFG_HEARTBEAT_HALF_MS, 24'($urandom_range(0, 12)));
				write_reg(uss_pkg::CFG_CONNECT_TIMEOUT, 24'($urandom_range(0, 600)));
				write_reg(uss_pkg::CFG_COMPLETE_DELAY, '0);
				write_reg(uss_pkg::CFG_BUTTON_HOLD, 24'($urandom_range(0, 40)));
				write_reg(uss_pkg::CFG_INACTIVITY_LIMIT, 24'($urandom_range(0, 1)));
				write_reg(uss_pkg::CFG_BUTTON_IDLE_LEVEL, 24'($urandom_range(0, 1)));
			end
			1: begin
				write_reg(uss_pkg::CFG_FEATURE_ENABLES,
					{20'd0, uss_pkg::RST_FEATURE_ENABLES});
				write_reg(uss_pkg::CFG_HEARTBEAT_HALF_MS, 24'($urandom_range(1, 40)));
				write_reg(uss_pkg::CFG_CONNECT_TIMEOUT, '1);
				write_reg(uss_pkg::CFG_COMPLETE_DELAY, 24'($urandom_range(1, 65534)));
				write_reg(uss_pkg::CFG_BUTTON_HOLD, 24'h00FFFF);
				write_reg(uss_pkg::CFG_INACTIVITY_LIMIT, 24'h00FFFF);
				write_reg(uss_pkg::CFG_BUTTON_IDLE_LEVEL, 24'($urandom_range(0, 1)));
			end
			default: begin
				write_reg(uss_pkg::CFG_FEATURE_ENABLES, 24'($urandom_range(0, 15)));
				write_reg(uss_pkg::CFG_HEARTBEAT_HALF_MS, 24'($urandom_range(1, 30)));
				write_reg(uss_pkg::CFG_CONNECT_TIMEOUT, 24'($urandom_range(1, 3000)));
				write_reg(uss_pkg::CFG_COMPLETE_DELAY, 24'h00FFFF);
				write_reg(uss_pkg::CFG_BUTTON_HOLD, 24'($urandom_range(1, 60)));
				write_reg(uss_pkg::CFG_INACTIVITY_LIMIT, 24'($urandom_range(2, 3)));
				write_reg(uss_pkg::CFG_BUTTON_IDLE_LEVEL, 24'($urandom_range(0, 1)));
			end
		endcase
		sent      = 0;
		rewritten = 1'b0;
		while (sent < RANDOM_QUOTA) begin
			// halfway: pause, then move the enables, period and idle level
			if (!rewritten && sent >= RANDOM_QUOTA / 2) begin
				rewritten = 1'b1;
				drain_block();
				write_reg(uss_pkg::CFG_FEATURE_ENABLES, 24'($urandom_range(0, 15)));
				write_reg(uss_pkg::CFG_HEARTBEAT_HALF_MS, 24'($urandom_range(0, 20)));
				write_reg(uss_pkg::CFG_BUTTON_IDLE_LEVEL, {23'd0, ~sup_regs.idle_level});
			end
			if ($urandom_range(0, 99) < 85) begin
				// one steady stretch; now and then a long one to run up idle seconds
				noisy = ($urandom_range(0, 11) != 0);
				len   = noisy ? $urandom_range(1, 80) : $urandom_range(200, 1100);
				// stay within the quota
				if (len > RANDOM_QUOTA - sent)
					len = RANDOM_QUOTA - sent;
				t.code    = ($urandom_range(0, 1) != 0) ? sup_st.last_code
					: 8'($urandom_range(0, 255));
				t.level   = 1'($urandom_range(0, 1));
				t.in_init = 1'($urandom_range(0, 1));
				t.done    = ($urandom_range(0, 3) == 0);
				repeat (len) begin
					item = t;
					if ($urandom_range(0, 15) == 0)
						item.level = ~item.level;
					if (noisy && $urandom_range(0, 31) == 0)
						item.code = 8'($urandom_range(0, 255));
					send_request(item, 1'b1);
					sent++;
				end
			end else begin
				item.level   = 1'($urandom_range(0, 1));
				item.code    = 8'($urandom_range(0, 255));
				item.in_init = 1'($urandom_range(0, 1));
				item.done    = 1'($urandom_range(0, 1));
				send_request(item, 1'b1);
				sent++;
			end
		end
	endtask

	// Provoke one exit, picked at random, then show that the result holds
	task automatic test_session_exit();
		logic [uss_pkg::REASON_W-1:0] cause;
		int unsigned                  n;
		tick_t                        t;
		drain_block();
		cause     = 3'($urandom_range(uss_pkg::REASON_CONNECT, uss_pkg::REASON_INACTIVITY));
		t.level   = sup_regs.idle_level;
		t.code    = 8'($urandom_range(0, 255));
		t.in_init = 1'b0;
		t.done    = 1'b0;
		case (cause)
			uss_pkg::REASON_CONNECT: begin
				// a zero timeout fires on the first tick in init
				write_reg(uss_pkg::CFG_FEATURE_ENABLES,
					{20'd0, sup_regs.feat | (4'b1 << uss_pkg::FEAT_CONNECT)});
				write_reg(uss_pkg::CFG_CONNECT_TIMEOUT, ($urandom_range(0, 1) != 0) ? '0
					: 24'(sup_st.since_start + $urandom_range(1, 8)));
				t.in_init = 1'b1;
			end
			uss_pkg::REASON_COMPLETED: begin
				write_reg(uss_pkg::CFG_COMPLETE_DELAY, 24'($urandom_range(0, 3)));
				t.done = 1'b1;
			end
			uss_pkg::REASON_BUTTON: begin
				write_reg(uss_pkg::CFG_FEATURE_ENABLES,
					{20'd0, sup_regs.feat | (4'b1 << uss_pkg::FEAT_BUTTON)});
				write_reg(uss_pkg::CFG_BUTTON_HOLD, 24'($urandom_range(0, 4)));
				t.level = ~sup_regs.idle_level;
			end
			default: begin
				// a zero limit fires at the first whole second
				write_reg(uss_pkg::CFG_FEATURE_ENABLES,
					{20'd0, sup_regs.feat | (4'b1 << uss_pkg::FEAT_INACTIVITY)});
				write_reg(uss_pkg::CFG_INACTIVITY_LIMIT, 24'($urandom_range(0, 1)));
			end
		endcase
		n = 0;
		while (sup_st.reason == uss_pkg::REASON_NONE && n < 4000) begin
			send_request(t, 1'b0);
			n++;
		end
		// anything goes now: the result must stay frozen
		repeat (20) begin
			t.level   = 1'($urandom_range(0, 1));
			t.code    = 8'($urandom_range(0, 255));
			t.in_init = 1'($urandom_range(0, 1));
			t.done    = 1'($urandom_range(0, 1));
			send_request(t, 1'b0);
		end
	endtask

	// Result checker: random back-pressure, compare against the oldest prediction
	initial begin
		outcome_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: led_level %0d finished %0d exit_reason %0d",
						rsp_ch.led_level, rsp_ch.finished, rsp_ch.exit_reason);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_ch.led_level !== want.led) begin
						$error("led_level: expected %0d, actual %0d", want.led,
							rsp_ch.led_level);
						fail_count++;
					end
					if (rsp_ch.finished !== want.finished) begin
						$error("finished: expected %0d, actual %0d", want.finished,
							rsp_ch.finished);
						fail_count++;
					end
					if (rsp_ch.exit_reason !== want.reason) begin
						$error("exit_reason: expected %0d, actual %0d", want.reason,
							rsp_ch.exit_reason);
						fail_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	// Main sequence
	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_data               <= '0;
		req_ch.valid           <= 1'b0;
		req_ch.button_level    <= 1'b0;
		req_ch.session_state   <= '0;
		req_ch.session_in_init <= 1'b0;
		req_ch.session_done    <= 1'b0;

		sup_regs.feat       = uss_pkg::RST_FEATURE_ENABLES;
		sup_regs.hb_half    = uss_pkg::RST_HEARTBEAT_HALF;
		sup_regs.conn_limit = uss_pkg::RST_CONNECT_TIMEOUT;
		sup_regs.done_delay = uss_pkg::RST_COMPLETE_DELAY;
		sup_regs.hold_limit = uss_pkg::RST_BUTTON_HOLD;
		sup_regs.idle_limit = uss_pkg::RST_INACTIVITY_LIM;
		sup_regs.idle_level = uss_pkg::RST_BUTTON_IDLE;
		sup_st              = '0;
		sup_st.btn_tracked  = uss_pkg::RST_BUTTON_IDLE;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// slow receiver, brisk sender
		test_power_on_defaults();
		test_heartbeat_periods();
		test_feature_masks();
		test_button_idle_swap();
		test_random_sessions(0);

		// slow sender, brisk receiver
		send_gap_pct = 76;
		recv_gap_pct = 9;
		test_random_sessions(1);

		// full rate on both sides
		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_random_sessions(2);
		test_session_exit();

		drain_block();
		if (fail_count == 0)
			$display("[update_session_supervisor_core] OK");
		else
			$display("[update_session_supervisor_core] ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/uss_pkg.sv
rtl/uss_req_if.sv
rtl/uss_rsp_if.sv
rtl/update_session_supervisor_core.sv
rtl/uss_checker.sv
sim/testbench.sv
